### src/dern_pkg.sv
// ============================================================================
// dern_pkg
// Shared constants for the four-band scheduler: sizes, codes and reset values.
// ============================================================================
package dern_pkg;

    // Size of each band's packet queue, in entries.
    localparam int FIFO_DEPTH = 1024;
    localparam int NUM_BANDS  = 4;

    // Widths that follow from the queue depth.
    localparam int HEAD_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_DELAY  = 3'd0;
    localparam logic [2:0] CFG_MIN_DELAY  = 3'd1;
    localparam logic [2:0] CFG_QUEUE_LIM  = 3'd2;
    localparam logic [2:0] CFG_ROUND_SEND = 3'd3;
    localparam logic [2:0] CFG_INTERVAL   = 3'd4;
    localparam logic [2:0] CFG_EWMA_W     = 3'd5;
    localparam logic [2:0] CFG_BAND_W     = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_ENQUEUED  = 3'd0;
    localparam logic [2:0] ST_DROP_TOT  = 3'd1;
    localparam logic [2:0] ST_DROP_FULL = 3'd2;
    localparam logic [2:0] ST_DEQUEUED  = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Register reset values.
    localparam logic [31:0] RST_MAX_DELAY  = 32'd25000;
    localparam logic [31:0] RST_MIN_DELAY  = 32'd20000;
    localparam logic [10:0] RST_QUEUE_LIM  = 11'd1000;
    localparam logic [15:0] RST_ROUND_SEND = 16'd10;
    localparam logic [31:0] RST_INTERVAL   = 32'd10000;
    localparam logic [16:0] RST_EWMA_W     = 17'd6554;
    localparam logic [31:0] RST_BAND_W     = 32'h0101_0101;

    // Arithmetic constants.
    localparam logic [39:0] RST_RATE   = 40'd10000000000;
    localparam logic [39:0] RATE_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [47:0] DELAY_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [29:0] NS_PER_S   = 30'd1000000000;
    localparam logic [10:0] PKT_BAND0  = 11'd52;
    localparam logic [10:0] PKT_OTHER  = 11'd1010;
    localparam logic [15:0] MARK_MIN   = 16'd52;
    localparam logic [16:0] EWMA_ONE   = 17'd65536;

endpackage

### src/delay_ecn_round_robin_scheduler.sv
// Flow, from the accepting edge to a valid result word: an enqueue runs the
// 48-step serial divider for the delay estimate; a total-limit drop and a
// saturated delay skip it. A dequeue scans the bands, then runs the 40-step
// divider when a rate update is due, unless the rate saturates. One word is in
// work at a time, and a held result adds its wait. Reset is synchronous and
// active low; queue storage is not cleared.
// ============================================================================
// delay_ecn_round_robin_scheduler
// Four-band weighted round-robin scheduler with delay-based ECN marking,
// built around one shared restoring divider under a small sequencer.
// ============================================================================
module delay_ecn_round_robin_scheduler
    import dern_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [47:0] i_now_ns,
    input  logic [7:0]  i_tos_byte,
    input  logic [15:0] i_packet_size,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_band,
    output logic [15:0] o_out_size,
    output logic        o_ecn_mark
);

    typedef enum logic [3:0] {
        S_IDLE, S_ENQ_MUL, S_ENQ_SETUP, S_DIV, S_ENQ_MARK,
        S_DQ_SCAN, S_DQ_RATE, S_DQ_MUL1, S_DQ_MUL2, S_DQ_SETUP,
        S_EWMA1, S_EWMA2, S_DQ_FIN, S_OUT
    } t_state;

    localparam int MEM_DEPTH = NUM_BANDS << HEAD_W;

    // Configuration registers.
    logic [31:0] r_max_delay, r_min_delay, r_interval, r_band_w;
    logic [10:0] r_queue_lim;
    logic [15:0] r_round_send;
    logic [16:0] r_ewma_w;

    // Per-band state.
    logic [HEAD_W-1:0] r_head  [NUM_BANDS];
    logic [CNT_W-1:0]  r_count [NUM_BANDS];
    logic [31:0]       r_bytes [NUM_BANDS];
    logic [15:0]       r_owed  [NUM_BANDS];
    logic [47:0]       r_prev  [NUM_BANDS];
    logic [39:0]       r_rate  [NUM_BANDS];
    logic [15:0]       r_sent  [NUM_BANDS];
    logic [47:0]       r_last  [NUM_BANDS];
    logic [7:0]        r_quant [NUM_BANDS];
    logic [1:0]        r_ptr;

    // Sequencer and working registers.
    t_state      r_state;
    logic        r_action;
    logic [47:0] r_now;
    logic [1:0]  r_band;
    logic [15:0] r_size;
    logic [2:0]  r_scan;
    logic [64:0] r_num;
    logic [26:0] r_prod;
    logic [47:0] r_div, r_rem, r_lo, r_quo, r_gap;
    logic [5:0]  r_it;
    logic        r_sat;
    logic [39:0] r_meas;
    logic [57:0] r_acc;

    // Queue storage.
    logic [15:0] r_mem [MEM_DEPTH];
    logic [15:0] r_rd_data;
    logic        mem_we, mem_re;
    logic [HEAD_W+1:0] mem_waddr, mem_raddr;

    // Output register.
    logic [2:0]  r_o_status;
    logic [1:0]  r_o_band;
    logic [15:0] r_o_size;
    logic        r_o_mark, r_o_valid;

    // Combinational helpers.
    logic [CNT_W+1:0]  total;
    logic [CNT_W:0]    slot_sum;
    logic [HEAD_W-1:0] slot;
    logic [47:0]       cur_delay;
    logic              band_full;
    logic [48:0]       div_trial;
    logic              div_ge;
    logic              gap_ok;
    logic              rate_due;
    logic [16:0]       ewma_w;
    logic [7:0]        cur_weight;
    logic [7:0]        quant_dec;
    logic              out_free;
    logic              out_load;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_band     = r_o_band;
    assign o_out_size = r_o_size;
    assign o_ecn_mark = r_o_mark;
    assign out_free   = !r_o_valid || !i_stall;
    assign out_load   = out_free && ((r_state == S_ENQ_MARK) || (r_state == S_DQ_FIN)
                                  || (r_state == S_OUT));

    // Occupancy, write slot and the band-full test for an enqueue.
    always_comb begin
        total = '0;
        for (int k = 0; k < NUM_BANDS; k++) begin
            total = total + (CNT_W+2)'(r_count[k]);
        end
    end
    assign slot_sum  = (CNT_W+1)'(r_head[r_band]) + (CNT_W+1)'(r_count[r_band]);
    assign slot      = (slot_sum >= (CNT_W+1)'(FIFO_DEPTH))
                       ? HEAD_W'(slot_sum - (CNT_W+1)'(FIFO_DEPTH))
                       : HEAD_W'(slot_sum);
    assign band_full = (32'(r_count[r_band]) >= 32'(r_queue_lim))
                    || (32'(r_count[r_band]) >= 32'(FIFO_DEPTH));
    assign cur_delay = r_sat ? DELAY_MAX : r_quo;

    // One restoring divider step.
    assign div_trial = {r_rem, r_lo[47]};
    assign div_ge    = div_trial >= {1'b0, r_div};

    // Rate update decision for the band being served.
    assign gap_ok   = r_now >= r_last[r_band];
    assign rate_due = (gap_ok && ((r_now - r_last[r_band]) >= 48'(r_interval))
                       && (r_sent[r_band] != '0))
                   || (r_sent[r_band] > r_round_send);
    assign ewma_w   = (r_ewma_w > EWMA_ONE) ? EWMA_ONE : r_ewma_w;

    assign cur_weight = r_band_w[8*r_band +: 8];
    assign quant_dec  = r_quant[r_band] - 8'd1;

    // Memory ports.
    assign mem_we    = (r_state == S_ENQ_MARK) && !band_full && out_free;
    assign mem_waddr = {r_band, slot};
    assign mem_re    = (r_state == S_DQ_SCAN) && (r_count[r_ptr] != '0);
    assign mem_raddr = {r_ptr, r_head[r_ptr]};

    // Queue storage with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_size;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Sequencer, per-band state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_delay  <= RST_MAX_DELAY;
            r_min_delay  <= RST_MIN_DELAY;
            r_queue_lim  <= RST_QUEUE_LIM;
            r_round_send <= RST_ROUND_SEND;
            r_interval   <= RST_INTERVAL;
            r_ewma_w     <= RST_EWMA_W;
            r_band_w     <= RST_BAND_W;
            for (int k = 0; k < NUM_BANDS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
                r_bytes[k] <= '0;
                r_owed[k]  <= '0;
                r_prev[k]  <= '0;
                r_rate[k]  <= RST_RATE;
                r_sent[k]  <= '0;
                r_last[k]  <= '0;
                r_quant[k] <= RST_BAND_W[8*k +: 8];
            end
            r_ptr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // A new word enters the output register, or the held one leaves.
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_DELAY:  r_max_delay  <= i_cfg_data;
                    CFG_MIN_DELAY:  r_min_delay  <= i_cfg_data;
                    CFG_QUEUE_LIM:  r_queue_lim  <= i_cfg_data[10:0];
                    CFG_ROUND_SEND: r_round_send <= i_cfg_data[15:0];
                    CFG_INTERVAL:   r_interval   <= i_cfg_data;
                    CFG_EWMA_W:     r_ewma_w     <= i_cfg_data[16:0];
                    CFG_BAND_W:     r_band_w     <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                // Take a new word.
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= i_action;
                        r_now    <= i_now_ns;
                        r_size   <= i_packet_size;
                        r_band   <= i_tos_byte[6:5];
                        r_scan   <= '0;
                        r_sat    <= 1'b0;
                        r_state  <= i_action ? S_DQ_SCAN : S_ENQ_MUL;
                    end
                end

                // Total limit check, then bytes times 8e9.
                S_ENQ_MUL: begin
                    if (32'(total) > 32'(r_queue_lim)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_num   <= {(62'(r_bytes[r_band]) * 62'(NS_PER_S)), 3'b000};
                        r_state <= S_ENQ_SETUP;
                    end
                end

                // Saturation test, then load the divider for the delay.
                S_ENQ_SETUP: begin
                    if (40'(r_num[64:48]) >= r_rate[r_band]) begin
                        r_sat   <= 1'b1;
                        r_state <= S_ENQ_MARK;
                    end else begin
                        r_div   <= 48'(r_rate[r_band]);
                        r_rem   <= 48'(r_num[64:48]);
                        r_lo    <= r_num[47:0];
                        r_it    <= 6'd48;
                        r_state <= S_DIV;
                    end
                end

                // Shared divider: one quotient bit per cycle.
                S_DIV: begin
                    r_rem <= div_ge ? 48'(div_trial - {1'b0, r_div}) : div_trial[47:0];
                    r_lo  <= {r_lo[46:0], 1'b0};
                    r_quo <= {r_quo[46:0], div_ge};
                    r_it  <= r_it - 6'd1;
                    if (r_it == 6'd1) begin
                        r_state <= r_action ? S_EWMA1 : S_ENQ_MARK;
                    end
                end

                // Mark decision and store of the packet.
                S_ENQ_MARK: begin
                    if (out_free) begin
                        if (cur_delay > 48'(r_max_delay) && r_band != 2'd0) begin
                            if (r_owed[r_band] != 16'hFFFF) begin
                                r_owed[r_band] <= r_owed[r_band] + 16'd1;
                            end
                        end else if (cur_delay > r_prev[r_band]
                                  && cur_delay > 48'(r_min_delay) && r_band != 2'd0) begin
                            if (r_owed[r_band] != 16'hFFFF) begin
                                r_owed[r_band] <= r_owed[r_band] + 16'd1;
                            end
                            r_prev[r_band] <= cur_delay;
                        end else if (cur_delay >= 48'(r_min_delay)) begin
                            r_prev[r_band] <= cur_delay;
                        end
                        if (band_full) begin
                            r_o_status <= ST_DROP_FULL;
                        end else begin
                            r_count[r_band] <= r_count[r_band] + CNT_W'(1);
                            r_bytes[r_band] <= r_bytes[r_band] + 32'(r_size);
                            r_o_status      <= ST_ENQUEUED;
                        end
                        r_o_band  <= r_band;
                        r_o_size  <= '0;
                        r_o_mark  <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end

                // Round-robin scan, one band per cycle.
                S_DQ_SCAN: begin
                    if (r_scan == 3'd4) begin
                        r_state <= S_OUT;
                    end else if (r_count[r_ptr] != '0) begin
                        r_band <= r_ptr;
                        r_head[r_ptr] <= (32'(r_head[r_ptr]) == FIFO_DEPTH - 1)
                                         ? '0 : r_head[r_ptr] + HEAD_W'(1);
                        r_count[r_ptr] <= r_count[r_ptr] - CNT_W'(1);
                        r_state <= S_DQ_RATE;
                    end else begin
                        r_quant[r_ptr] <= r_band_w[8*r_ptr +: 8];
                        r_ptr  <= r_ptr + 2'd1;
                        r_scan <= r_scan + 3'd1;
                    end
                end

                // Decide whether this dequeue refreshes the rate estimate.
                S_DQ_RATE: begin
                    r_gap <= gap_ok ? r_now - r_last[r_band] : '0;
                    if (rate_due) begin
                        r_state <= S_DQ_MUL1;
                    end else begin
                        if (r_sent[r_band] != 16'hFFFF) begin
                            r_sent[r_band] <= r_sent[r_band] + 16'd1;
                        end
                        r_state <= S_DQ_FIN;
                    end
                end

                // Packets times bytes per packet.
                S_DQ_MUL1: begin
                    r_prod  <= 27'(r_sent[r_band])
                             * 27'((r_band == 2'd0) ? PKT_BAND0 : PKT_OTHER);
                    r_state <= S_DQ_MUL2;
                end

                // Times 8e9 bits-ns per byte-s.
                S_DQ_MUL2: begin
                    r_num   <= {2'b00, 60'(60'(r_prod) * 60'(NS_PER_S)), 3'b000};
                    r_state <= S_DQ_SETUP;
                end

                // Saturation test, then load the divider for the rate.
                S_DQ_SETUP: begin
                    if (48'(r_num[58:40]) >= r_gap) begin
                        r_sat   <= 1'b1;
                        r_state <= S_EWMA1;
                    end else begin
                        r_div   <= r_gap;
                        r_rem   <= 48'(r_num[58:40]);
                        r_lo    <= {r_num[39:0], 8'h00};
                        r_it    <= 6'd40;
                        r_state <= S_DIV;
                    end
                end

                // Old rate share of the average.
                S_EWMA1: begin
                    r_meas  <= r_sat ? RATE_MAX : r_quo[39:0];
                    r_acc   <= 58'(r_rate[r_band]) * 58'(EWMA_ONE - ewma_w);
                    r_state <= S_EWMA2;
                end

                // Measured rate share and the new estimate.
                S_EWMA2: begin
                    r_rate[r_band] <= 40'((r_acc + 58'(r_meas) * 58'(ewma_w)) >> 16);
                    r_last[r_band] <= r_now;
                    r_sent[r_band] <= '0;
                    r_state        <= S_DQ_FIN;
                end

                // Mark, byte count, quantum and the result word.
                S_DQ_FIN: begin
                    if (out_free) begin
                        if (r_owed[r_band] != '0 && r_rd_data > MARK_MIN) begin
                            r_o_mark       <= 1'b1;
                            r_owed[r_band] <= r_owed[r_band] - 16'd1;
                        end else begin
                            r_o_mark <= 1'b0;
                        end
                        r_bytes[r_band] <= (r_bytes[r_band] >= 32'(r_rd_data))
                                           ? r_bytes[r_band] - 32'(r_rd_data) : '0;
                        if (quant_dec == 8'd0) begin
                            r_quant[r_band] <= cur_weight;
                            r_ptr           <= r_ptr + 2'd1;
                        end else begin
                            r_quant[r_band] <= quant_dec;
                        end
                        r_o_status <= ST_DEQUEUED;
                        r_o_band   <= r_band;
                        r_o_size   <= r_rd_data;
                        r_state    <= S_IDLE;
                    end
                end

                // Empty dequeue or total-limit drop: no packet data to return.
                S_OUT: begin
                    if (out_free) begin
                        r_o_status <= r_action ? ST_EMPTY : ST_DROP_TOT;
                        r_o_band   <= r_action ? 2'd0 : r_band;
                        r_o_size   <= '0;
                        r_o_mark   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
